>>> src/substring_window_matcher_macros.svh
// ----------------------------------------------------------------------------
// Substring window matcher assertion macros
// Shared property shapes for the matcher's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_WINDOW_MATCHER_MACROS_SVH
`define SUBSTRING_WINDOW_MATCHER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SWM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and types of the substring window matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int BYTE_W          = 8;

  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_TEXT    = 1'b1;

  typedef struct packed {
    logic              pat_wr;
    logic              txt_wr;
    logic              last;
    logic [BYTE_W-1:0] data;
  } swm_op_t;

endpackage

`default_nettype wire

>>> src/swm_if.sv
// ----------------------------------------------------------------------------
// swm_in_if / swm_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface swm_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output command, output data_byte, output last,
                  input ready);
  modport sink   (input valid, input command, input data_byte, input last,
                  output ready);
endinterface

interface swm_out_if;
  logic valid;
  logic ready;
  logic found;
  logic pattern_overflow;

  modport source (output valid, output found, output pattern_overflow, input ready);
  modport sink   (input valid, input found, input pattern_overflow, output ready);
endinterface

`default_nettype wire

>>> src/substring_window_matcher.sv
// ----------------------------------------------------------------------------
// substring_window_matcher
// Naive substring search: loads a pattern, slides text through a window.
// ----------------------------------------------------------------------------
// channel   dir  handshake      word
// in_chan   in   valid/ready    command, data_byte, last
// out_chan  out  valid/ready    found, pattern_overflow
//
// One word is taken every cycle unless a waiting result holds a last text word;
// its result passes through the input register and then the result register.
// The whole window is compared against the pattern in parallel each cycle.
// Reset is synchronous; no clearing pass is needed.
// A waiting result stalls a later last text word and those behind it; others pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "substring_window_matcher_macros.svh"

module substring_window_matcher import swm_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  localparam int LEN_W      = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  swm_in_if.sink     in_chan,
  swm_out_if.source  out_chan
);

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_cmd_r;
  logic [BYTE_W-1:0] s1_data_r;
  logic              s1_last_r;
  logic              s1_is_result, s1_go, in_acc;
  logic              out_valid_r, out_valid_nxt;
  logic              found_r, ovf_r;
  swm_op_t           op;

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_bytes;
  logic [LEN_W-1:0]                   pat_len;
  logic                               pat_ovf, found_w;

  always_comb begin
    s1_is_result   = (s1_cmd_r == CMD_TEXT) && s1_last_r;
    s1_go          = s1_valid_r && (!s1_is_result || !out_valid_r || out_chan.ready);
    in_chan.ready  = !s1_valid_r || s1_go;
    in_acc         = in_chan.valid && in_chan.ready;
    s1_valid_nxt   = in_acc ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    op.pat_wr      = s1_go && (s1_cmd_r == CMD_PATTERN);
    op.txt_wr      = s1_go && (s1_cmd_r == CMD_TEXT);
    op.last        = s1_last_r;
    op.data        = s1_data_r;
    out_valid_nxt  = (s1_go && s1_is_result) ? 1'b1
                   : (out_chan.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= in_chan.command;
      s1_data_r <= in_chan.data_byte;
      s1_last_r <= in_chan.last;
    end
    if (s1_go && s1_is_result) begin
      found_r <= found_w;
      ovf_r   <= pat_ovf;
    end
  end

  swm_pattern #(.MAX_PATTERN(MAX_PATTERN)) u_pattern (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (op),
    .pat_bytes_o (pat_bytes),
    .pat_len_o   (pat_len),
    .pat_ovf_o   (pat_ovf)
  );

  swm_window #(.MAX_PATTERN(MAX_PATTERN)) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (op),
    .pat_bytes_i (pat_bytes),
    .pat_len_i   (pat_len),
    .pat_ovf_i   (pat_ovf),
    .found_o     (found_w)
  );

  assign out_chan.valid            = out_valid_r;
  assign out_chan.found            = found_r;
  assign out_chan.pattern_overflow = ovf_r;

  `SWM_ASSERT_NOW(a_found_excl_ovf, out_valid_r && found_r, !ovf_r, "found with overflow")
  `SWM_ASSERT_NEXT(a_result_loaded, s1_go && s1_is_result, out_valid_r, "result dropped")
  `SWM_ASSERT_NEXT(a_word_staged, in_acc, s1_valid_r, "accepted word not staged")
  `SWM_ASSERT_NOW(a_len_bound, 1'b1, pat_len <= LEN_W'(MAX_PATTERN), "pattern length overrun")

endmodule

`default_nettype wire

>>> src/swm_pattern.sv
// ----------------------------------------------------------------------------
// swm_pattern
// Pattern store: newest byte at entry 0, length, completion and overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_pattern import swm_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  localparam int LEN_W      = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire swm_op_t                               op,
  output logic [MAX_PATTERN-1:0][BYTE_W-1:0]         pat_bytes_o,
  output logic [LEN_W-1:0]                           pat_len_o,
  output logic                                       pat_ovf_o
);

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_r, pat_nxt;
  logic [LEN_W-1:0]                   len_r, len_nxt, len_base;
  logic                               ovf_r, ovf_nxt, ovf_base;
  logic                               done_r, done_nxt;
  logic                               shift;

  always_comb begin
    len_base = done_r ? '0 : len_r;
    ovf_base = done_r ? 1'b0 : ovf_r;
    len_nxt  = len_r;
    ovf_nxt  = ovf_r;
    done_nxt = done_r;
    shift    = 1'b0;
    if (op.pat_wr) begin
      done_nxt = op.last;
      if (len_base < LEN_W'(MAX_PATTERN)) begin
        len_nxt = len_base + 1'b1;
        ovf_nxt = ovf_base;
        shift   = 1'b1;
      end else begin
        len_nxt = len_base;
        ovf_nxt = 1'b1;
      end
    end else if (op.txt_wr) begin
      done_nxt = 1'b1;
    end
  end

  always_comb begin
    pat_nxt[0] = op.data;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      pat_nxt[i] = pat_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      ovf_r  <= 1'b0;
      done_r <= 1'b1;
    end else begin
      len_r  <= len_nxt;
      ovf_r  <= ovf_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      pat_r <= pat_nxt;
    end
  end

  assign pat_bytes_o = pat_r;
  assign pat_len_o   = len_r;
  assign pat_ovf_o   = ovf_r;

endmodule

`default_nettype wire

>>> src/swm_window.sv
// ----------------------------------------------------------------------------
// swm_window
// Text window, byte count, parallel compare and remembered hit.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_window import swm_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  localparam int LEN_W      = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire swm_op_t                               op,
  input  wire logic [MAX_PATTERN-1:0][BYTE_W-1:0]    pat_bytes_i,
  input  wire logic [LEN_W-1:0]                      pat_len_i,
  input  wire logic                                  pat_ovf_i,
  output logic                                       found_o
);

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_r, win_nxt;
  logic [LEN_W-1:0]                   cnt_r, cnt_nxt, cnt_inc;
  logic                               hit_r, hit_nxt;
  logic                               match, hit_now;

  always_comb begin
    win_nxt[0] = op.data;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_nxt[i] = win_r[i-1];
    end
  end

  always_comb begin
    match = 1'b1;
    for (int w = 0; w < MAX_PATTERN; w++) begin
      if ((LEN_W'(w) < pat_len_i) && (win_nxt[w] != pat_bytes_i[w])) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    cnt_inc = (cnt_r < LEN_W'(MAX_PATTERN)) ? cnt_r + 1'b1 : cnt_r;
    hit_now = !pat_ovf_i && (cnt_inc >= pat_len_i) && match;
    found_o = (hit_r || hit_now) && !pat_ovf_i;
    cnt_nxt = cnt_r;
    hit_nxt = hit_r;
    if (op.pat_wr) begin
      cnt_nxt = '0;
      hit_nxt = 1'b0;
    end else if (op.txt_wr) begin
      if (op.last) begin
        cnt_nxt = '0;
        hit_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_inc;
        hit_nxt = hit_r || hit_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      hit_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op.txt_wr) begin
      win_r <= win_nxt;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/swm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swm_checker
// Watches the input and result channels of the substring window matcher,
// tracks the pattern and text window of its own, and compares every result
// word with the oldest predicted verdict.
// ----------------------------------------------------------------------------
module swm_checker import swm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  swm_in_if         in_mon,
  swm_out_if        out_mon,
  output int        fail_count,
  output int        verdicts_pending
);

  localparam int DEPTH = MAX_PATTERN_DEF;

  typedef struct packed {
    logic found;
    logic overflow;
  } verdict_t;

  logic [BYTE_W-1:0] pat_bytes [DEPTH];
  int                pat_len;
  bit                pat_closed;
  bit                pat_overflow;
  logic [BYTE_W-1:0] window [DEPTH];
  int                seen_cnt;
  bit                hit;
  verdict_t          verdict_q [$];

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic void clear_text();
    for (int k = 0; k < DEPTH; k++) window[k] = '0;
    seen_cnt = 0;
    hit      = 1'b0;
  endfunction

  function automatic bit window_hit();
    for (int p = 0; p < pat_len; p++)
      if (window[pat_len - 1 - p] !== pat_bytes[p]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit search_step(input logic cmd, input logic [BYTE_W-1:0] data,
                                     input logic lst, output verdict_t v);
    v = '0;
    if (cmd == CMD_PATTERN) begin
      if (pat_closed) begin
        pat_len      = 0;
        pat_overflow = 1'b0;
        pat_closed   = 1'b0;
      end
      clear_text();
      if (pat_len < DEPTH) begin
        pat_bytes[pat_len] = data;
        pat_len++;
      end else begin
        pat_overflow = 1'b1;
      end
      if (lst) pat_closed = 1'b1;
      return 1'b0;
    end
    pat_closed = 1'b1;
    for (int k = DEPTH - 1; k > 0; k--) window[k] = window[k - 1];
    window[0] = data;
    if (seen_cnt < DEPTH) seen_cnt++;
    if (!pat_overflow && seen_cnt >= pat_len && window_hit()) hit = 1'b1;
    if (!lst) return 1'b0;
    v.found    = hit && !pat_overflow;
    v.overflow = pat_overflow;
    clear_text();
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (!rst_n) begin
      pat_len      = 0;
      pat_closed   = 1'b1;
      pat_overflow = 1'b0;
      clear_text();
      verdict_q.delete();
      fail_count   = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.found    = out_mon.found;
        got.overflow = out_mon.pattern_overflow;
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result word found=%0b overflow=%0b",
                                    got.found, got.overflow));
        end else begin
          want = verdict_q.pop_front();
          if (got.found !== want.found)
            report_mismatch($sformatf("found got %0b want %0b", got.found, want.found));
          if (got.overflow !== want.overflow)
            report_mismatch($sformatf("pattern_overflow got %0b want %0b",
                                      got.overflow, want.overflow));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (search_step(in_mon.command, in_mon.data_byte, in_mon.last, want))
          verdict_q.push_back(want);
      end
    end
    verdicts_pending = verdict_q.size();
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives pattern and text words into the substring window matcher: a short
// directed run over the corner cases, then random patterns with texts that
// often embed them, under bursty input and a stalling result receiver.
// ----------------------------------------------------------------------------
module testbench import swm_pkg::*;;

  localparam int WORD_TARGET = 1400;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   verdicts_pending;
  int   burst_left;
  int   words_sent;

  swm_in_if  in_chan ();
  swm_out_if out_chan ();

  substring_window_matcher DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  swm_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_chan),
    .out_mon          (out_chan),
    .fail_count       (fail_count),
    .verdicts_pending (verdicts_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : sink_stalls
    int stall_left;
    int cyc;
    out_chan.ready = 1'b0;
    stall_left     = 0;
    cyc            = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (!rst_n) begin
        out_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else if ((cyc / 500) % 3 != 0 && $urandom_range(0, 3) == 0) begin
        out_chan.ready <= 1'b0;
        stall_left = $urandom_range(0, 7);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] pick_byte(input bit wide);
    logic [7:0] alphabet [4];
    alphabet = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
    if (wide) return 8'($urandom_range(0, 255));
    return alphabet[$urandom_range(0, 3)];
  endfunction

  task automatic pause_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_chan.valid     <= 1'b0;
      in_chan.command   <= 1'($urandom_range(0, 1));
      in_chan.data_byte <= 8'($urandom_range(0, 255));
      in_chan.last      <= 1'($urandom_range(0, 1));
    end
  endtask

  task automatic send_word(input logic cmd, input logic [7:0] data, input logic lst);
    if (burst_left == 0) begin
      pause_sender($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    @(negedge clk);
    in_chan.valid     <= 1'b1;
    in_chan.command   <= cmd;
    in_chan.data_byte <= data;
    in_chan.last      <= lst;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain_verdicts();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (verdicts_pending != 0) @(negedge clk);
  endtask

  task automatic run_search_sequence();
    logic [7:0] pat [$];
    bit         wide;
    bit         unfinished;
    bit         embed;
    bit         abandon;
    int         plen;
    int         pick;
    int         ntext;
    int         tlen;
    int         pos;
    logic [7:0] b;
    wide       = ($urandom_range(0, 3) == 0);
    unfinished = ($urandom_range(0, 7) == 0);
    pick       = $urandom_range(0, 19);
    if (pick < 14)       plen = $urandom_range(1, 4);
    else if (pick < 17)  plen = $urandom_range(5, 15);
    else if (pick == 17) plen = MAX_PATTERN_DEF;
    else                 plen = $urandom_range(MAX_PATTERN_DEF + 1, MAX_PATTERN_DEF + 4);
    for (int k = 0; k < plen; k++) begin
      b = pick_byte(wide);
      pat.push_back(b);
      send_word(CMD_PATTERN, b, (k == plen - 1) && !unfinished);
    end
    ntext = $urandom_range(1, 3);
    for (int t = 0; t < ntext; t++) begin
      tlen    = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 24)
                                            : $urandom_range(1, plen + 6);
      embed   = $urandom_range(0, 1);
      abandon = ($urandom_range(0, 11) == 0);
      pos     = (tlen >= plen) ? $urandom_range(0, tlen - plen) : 0;
      for (int j = 0; j < tlen; j++) begin
        if (embed && tlen >= plen && j >= pos && j < pos + plen) b = pat[j - pos];
        else b = pick_byte(wide);
        send_word(CMD_TEXT, b, (j == tlen - 1) && !abandon);
      end
      if (abandon) break;
    end
  endtask

  initial begin : stimulus
    int next_drain;
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.command   = CMD_PATTERN;
    in_chan.data_byte = 8'h00;
    in_chan.last      = 1'b0;
    burst_left        = 0;
    words_sent        = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // empty pattern after reset matches any text
    send_word(CMD_TEXT, 8'h00, 1'b1);
    // text shorter than the pattern
    send_word(CMD_PATTERN, 8'hFF, 1'b0);
    send_word(CMD_PATTERN, 8'h00, 1'b1);
    send_word(CMD_TEXT, 8'hFF, 1'b1);
    // unfinished pattern taken by text, then a pattern word abandons that text
    send_word(CMD_PATTERN, 8'h3C, 1'b0);
    send_word(CMD_TEXT, 8'h3C, 1'b0);
    send_word(CMD_PATTERN, 8'hC3, 1'b0);
    send_word(CMD_TEXT, 8'hC3, 1'b1);
    // pattern one byte too long
    for (int k = 0; k <= MAX_PATTERN_DEF; k++)
      send_word(CMD_PATTERN, 8'(8'h80 + k), k == MAX_PATTERN_DEF);
    send_word(CMD_TEXT, 8'h80, 1'b1);
    drain_verdicts();

    next_drain = words_sent + 250;
    while (words_sent < WORD_TARGET) begin
      run_search_sequence();
      if (words_sent >= next_drain) begin
        drain_verdicts();
        next_drain = words_sent + 250;
      end
    end

    drain_verdicts();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && verdicts_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
